/* design/selective_repeat_receiver_unit_assert.svh */
// ----------------------------------------------------------------------------
// selective repeat receiver assertion macros
// shared property forms for the receiver's own checks
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication
`define SRR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/srr_pkg.sv */
// ----------------------------------------------------------------------------
// srr_pkg
// types and constants of the selective repeat receiver
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int SEQ_SPACE    = 16;
    localparam int SEQ_W        = $clog2(SEQ_SPACE);
    localparam int PAYLOAD_BITS = 32;
    localparam int MAX_DELIVER  = 8;
    localparam int CNT_W        = $clog2(MAX_DELIVER);
    localparam int WIN_W        = 4;
    localparam int WIN_CAP      = (SEQ_SPACE / 2 < MAX_DELIVER) ? SEQ_SPACE / 2 : MAX_DELIVER;
    localparam int WIN_RESET    = 8;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [APB_ADDR_W-3:0] REG_WINDOW_SIZE = '0;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic        checksum_ok;
        logic [3:0]  seq_num;
        logic [31:0] payload;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [3:0]  ack_num;
        logic [31:0] delivered_data;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic                    we;
        logic [SEQ_W-1:0]        waddr;
        logic [PAYLOAD_BITS-1:0] wdata;
        logic [SEQ_W-1:0]        raddr;
    } t_ram_req;

    typedef struct packed {
        logic             busy;
        logic [SEQ_W-1:0] base;
    } t_ctrl_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DELIVER
    } t_state;

endpackage

/* design/srr_data_ram.sv */
// ----------------------------------------------------------------------------
// srr_data_ram
// held payload store, one write port and one registered read port
// ----------------------------------------------------------------------------
module srr_data_ram (
    input  logic                                i_clk,
    input  srr_pkg::t_ram_req                   i_req,
    output logic [srr_pkg::PAYLOAD_BITS-1:0]    o_rdata
);

    logic [srr_pkg::PAYLOAD_BITS-1:0] r_mem [srr_pkg::SEQ_SPACE];
    logic [srr_pkg::PAYLOAD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/srr_ctrl.sv */
// ----------------------------------------------------------------------------
// srr_ctrl
// window check, held marks, delivery sequencer and output register
// ----------------------------------------------------------------------------
module srr_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [srr_pkg::WIN_W-1:0]           i_win_size,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  srr_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output srr_pkg::t_out_item                  o_out_item,
    output srr_pkg::t_ram_req                   o_ram_req,
    input  logic [srr_pkg::PAYLOAD_BITS-1:0]    i_ram_rdata,
    output srr_pkg::t_ctrl_status               o_status
);

    srr_pkg::t_state                r_state, n_state;
    logic [srr_pkg::SEQ_W-1:0]      r_base, n_base;
    logic [srr_pkg::SEQ_SPACE-1:0]  r_mark, n_mark;
    logic [srr_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                           r_out_valid, n_out_valid;
    srr_pkg::t_out_item             r_out, n_out;

    logic                           out_free;
    logic                           accept;
    logic [srr_pkg::SEQ_W-1:0]      seq;
    logic [srr_pkg::SEQ_W-1:0]      offset;
    logic [srr_pkg::WIN_W-1:0]      eff_win;
    logic                           in_win;
    logic                           good;
    logic                           store;
    logic                           deliver;
    logic [srr_pkg::SEQ_W-1:0]      base_inc;
    logic                           dlv_last;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == srr_pkg::ST_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    assign seq      = i_in_item.seq_num[srr_pkg::SEQ_W-1:0];
    assign offset   = seq - r_base;
    assign eff_win  = (i_win_size > srr_pkg::WIN_W'(srr_pkg::WIN_CAP))
                      ? srr_pkg::WIN_W'(srr_pkg::WIN_CAP) : i_win_size;
    assign in_win   = srr_pkg::WIN_W'(offset) < eff_win;
    assign good     = accept && i_in_item.checksum_ok;
    assign store    = good && in_win && !r_mark[seq];
    assign deliver  = good && in_win && (seq == r_base);
    assign base_inc = r_base + srr_pkg::SEQ_W'(1);
    assign dlv_last = (r_cnt == srr_pkg::CNT_W'(srr_pkg::MAX_DELIVER - 1)) || !r_mark[base_inc];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srr_pkg::ST_IDLE: begin
                if (deliver) begin
                    n_state = srr_pkg::ST_READ;
                end
            end
            srr_pkg::ST_READ: begin
                n_state = srr_pkg::ST_DELIVER;
            end
            srr_pkg::ST_DELIVER: begin
                if (out_free) begin
                    n_state = dlv_last ? srr_pkg::ST_IDLE : srr_pkg::ST_READ;
                end
            end
            default: begin
                n_state = srr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_base      = r_base;
        n_mark      = r_mark;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = seq;
        o_ram_req.wdata = i_in_item.payload;
        o_ram_req.raddr = r_base;
        unique case (r_state)
            srr_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (good) begin
                    n_out_valid            = 1'b1;
                    n_out.kind             = srr_pkg::KIND_ACK;
                    n_out.ack_num          = i_in_item.seq_num;
                    n_out.delivered_data   = '0;
                    n_out.last             = !deliver;
                end
                if (store) begin
                    o_ram_req.we = 1'b1;
                    n_mark[seq]  = 1'b1;
                end
            end
            srr_pkg::ST_READ: begin
            end
            srr_pkg::ST_DELIVER: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.kind           = srr_pkg::KIND_DATA;
                    n_out.ack_num        = '0;
                    n_out.delivered_data = i_ram_rdata;
                    n_out.last           = dlv_last;
                    n_mark[r_base]       = 1'b0;
                    n_base               = base_inc;
                    n_cnt                = r_cnt + srr_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srr_pkg::ST_IDLE;
            r_base      <= srr_pkg::SEQ_W'(1);
            r_mark      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_mark      <= n_mark;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_item    = r_out;
    assign o_status.busy = (r_state != srr_pkg::ST_IDLE);
    assign o_status.base = r_base;

endmodule

/* design/selective_repeat_receiver_unit.sv */
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit
// selective repeat arq receiver: acks good packets, buffers in-window
// payloads and delivers them in order as the window base advances
// ----------------------------------------------------------------------------
// A good packet that does not reach the window base produces one ack item
// and the input takes the next packet in the following cycle once the output
// register is free. A good packet at the window base holds the input until its
// delivery run of n payloads (1 to 8) ends: every delivery first reads the
// payload memory, whose read data is registered, and then loads the output
// register once it is free. Held marks live in flip-flops cleared by reset,
// so no clearing pass is needed. window_size sits at byte address 0.
// ----------------------------------------------------------------------------
`include "selective_repeat_receiver_unit_assert.svh"

module selective_repeat_receiver_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [srr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [srr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  srr_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output srr_pkg::t_out_item                  o_out_item
);

    logic [srr_pkg::WIN_W-1:0]          r_win_size;
    logic                               cfg_sel;
    srr_pkg::t_ram_req                  ram_req;
    logic [srr_pkg::PAYLOAD_BITS-1:0]   ram_rdata;
    srr_pkg::t_ctrl_status              status;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[srr_pkg::APB_ADDR_W-1:2] == srr_pkg::REG_WINDOW_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= srr_pkg::WIN_W'(srr_pkg::WIN_RESET);
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_win_size <= pwdata[srr_pkg::WIN_W-1:0];
        end
    end

    assign prdata = cfg_sel ? srr_pkg::APB_DATA_W'(r_win_size) : '0;

    srr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_size  (r_win_size),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_status    (status)
    );

    srr_data_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // a good packet at the base with a nonzero window starts a delivery run
    `SRR_ASSERT_NEXT(a_base_hit_delivers, i_in_valid && o_in_ready && i_in_item.checksum_ok && (i_in_item.seq_num[srr_pkg::SEQ_W-1:0] == status.base) && (r_win_size != '0), status.busy, "base packet did not start delivery")

    // the base moves only together with a delivered item
    `SRR_ASSERT_SAME(a_base_moves_on_data, $past(status.base) != status.base, o_out_valid && (o_out_item.kind == srr_pkg::KIND_DATA), "base moved without delivery")

    // no input item is taken while deliveries are running
    `SRR_ASSERT_SAME(a_no_accept_busy, status.busy, !o_in_ready, "input accepted during delivery")

endmodule

/* test/srr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srr_checker
// watches the register port and both item channels of the selective repeat
// receiver, tracks window base, held marks and held payloads on its own, and
// compares every result item in order with the acks and deliveries it predicts
// ----------------------------------------------------------------------------
module srr_checker
    import srr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_item,
    output int                    o_fail_count,
    output int                    o_pending,
    output logic [SEQ_W-1:0]      o_win_base
);

    logic [WIN_W-1:0]        win_size;
    logic [SEQ_W-1:0]        win_base;
    logic                    held_mark [SEQ_SPACE];
    logic [PAYLOAD_BITS-1:0] held_data [SEQ_SPACE];
    t_out_item               due_items [$];
    int                      fail_count = 0;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t srr mismatch: %s", $time, what);
    endtask

    task automatic absorb_packet(input t_in_item pkt);
        t_out_item        res;
        logic [SEQ_W-1:0] slot;
        logic [SEQ_W-1:0] offset;
        logic [WIN_W-1:0] eff;
        int               d;
        if (!pkt.checksum_ok) begin
            return;
        end
        res = '0;
        res.kind = KIND_ACK;
        res.ack_num = pkt.seq_num;
        res.last = 1'b1;
        slot = pkt.seq_num;
        offset = slot - win_base;
        eff = (win_size > WIN_CAP) ? WIN_W'(WIN_CAP) : win_size;
        if (offset < eff) begin
            if (!held_mark[slot]) begin
                held_mark[slot] = 1'b1;
                held_data[slot] = pkt.payload;
            end
            if (slot == win_base) begin
                d = 0;
                while (d < MAX_DELIVER && held_mark[win_base]) begin
                    res.last = 1'b0;
                    due_items.push_back(res);
                    res = '0;
                    res.kind = KIND_DATA;
                    res.delivered_data = held_data[win_base];
                    res.last = 1'b1;
                    held_mark[win_base] = 1'b0;
                    win_base = win_base + 1'b1;
                    d++;
                end
            end
        end
        due_items.push_back(res);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (due_items.size() == 0) begin
            report_mismatch($sformatf("unexpected item kind %0d ack %0d data %h last %0d",
                                      got.kind, got.ack_num, got.delivered_data, got.last));
            return;
        end
        want = due_items.pop_front();
        if (got.kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        end
        if (got.ack_num !== want.ack_num) begin
            report_mismatch($sformatf("ack_num %0d, want %0d", got.ack_num, want.ack_num));
        end
        if (got.delivered_data !== want.delivered_data) begin
            report_mismatch($sformatf("delivered_data %h, want %h",
                                      got.delivered_data, want.delivered_data));
        end
        if (got.last !== want.last) begin
            report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_size = WIN_W'(WIN_RESET);
            win_base = SEQ_W'(1);
            foreach (held_mark[i]) begin
                held_mark[i] = 1'b0;
            end
            due_items.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_item);
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[APB_ADDR_W-1:2] == REG_WINDOW_SIZE) begin
                win_size = i_pwdata[WIN_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                absorb_packet(i_in_item);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= due_items.size();
        o_win_base   <= win_base;
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives the selective repeat receiver with directed and random packet
// traffic over several window sizes, with bursty input and a stalling result
// side, and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb;
    import srr_pkg::*;

    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 15;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;

    int                    fail_count;
    int                    pending_items;
    logic [SEQ_W-1:0]      rx_base;

    logic [7:0]            stall_pattern = 8'hFF;
    logic [5:0]            stall_phase = '0;
    int                    burst_left = 0;
    int                    sent_count = 0;

    selective_repeat_receiver_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    srr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending_items),
        .o_win_base   (rx_base)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side stalls on a repeating 8-bit pattern, renewed each time the 6-bit phase counter wraps
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_phase == '0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern <= 8'hFF;
                1: stall_pattern <= 8'($urandom()) | 8'h01;
                2: stall_pattern <= 8'h01;
                default: stall_pattern <= 8'hAA;
            endcase
        end
        i_out_ready <= stall_pattern[stall_phase[2:0]];
    end

    task automatic send_packet(input logic ok, input logic [3:0] seq, input logic [31:0] data);
        t_in_item pkt;
        int       gap;
        pkt.checksum_ok = ok;
        pkt.seq_num = seq;
        pkt.payload = data;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item <= pkt;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        sent_count++;
    endtask

    // the pending count is registered, so wait for it to read zero and then let the drain cycles pass
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_items != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] size);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_WINDOW_SIZE, 2'b00};
        pwdata <= APB_DATA_W'(size);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one sender window: consecutive numbers from the base in shuffled order,
    // sometimes missing the base, plus a little noise
    task automatic send_round(input int win);
        t_in_item         round_q [$];
        t_in_item         pkt;
        t_in_item         tmp;
        logic [SEQ_W-1:0] base;
        int               eff;
        int               n;
        int               i;
        int               j;
        base = rx_base;
        eff = (win > WIN_CAP) ? WIN_CAP : win;
        n = (eff == 0) ? $urandom_range(1, 4) : $urandom_range(1, eff);
        for (i = 0; i < n; i++) begin
            pkt.checksum_ok = 1'b1;
            pkt.seq_num = base + 4'(i);
            pkt.payload = $urandom();
            round_q.push_back(pkt);
        end
        if ($urandom_range(0, 4) == 0) begin
            round_q.delete(0);
        end
        repeat ($urandom_range(0, 2)) begin
            pkt.payload = $urandom();
            case ($urandom_range(0, 2))
                0: begin
                    pkt.checksum_ok = 1'b0;
                    pkt.seq_num = 4'($urandom());
                end
                1: begin
                    pkt.checksum_ok = 1'b1;
                    pkt.seq_num = base + 4'($urandom_range(eff, 15));
                end
                default: begin
                    pkt.checksum_ok = 1'b1;
                    pkt.seq_num = base + 4'($urandom_range(0, n - 1));
                end
            endcase
            round_q.push_back(pkt);
        end
        for (i = round_q.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = round_q[i];
            round_q[i] = round_q[j];
            round_q[j] = tmp;
        end
        foreach (round_q[k]) begin
            send_packet(round_q[k].checksum_ok, round_q[k].seq_num, round_q[k].payload);
        end
    endtask

    initial begin
        int win_list [9];
        int start;
        win_list = '{1, 0, 15, 4, 8, 2, 15, 6, 3};
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // window 8 from reset, base 1
        send_packet(1'b0, 4'd1, 32'hFFFF_FFFF);
        send_packet(1'b0, 4'd15, 32'h0000_0000);
        send_packet(1'b1, 4'd0, 32'h0000_0000);
        send_packet(1'b1, 4'd9, 32'h1234_5678);
        send_packet(1'b1, 4'd3, 32'h0000_0000);
        send_packet(1'b1, 4'd3, 32'hFFFF_FFFF);
        send_packet(1'b1, 4'd2, 32'hFFFF_FFFF);
        send_packet(1'b1, 4'd8, 32'hA5A5_A5A5);
        send_packet(1'b1, 4'd1, 32'h5A5A_5A5A);
        for (int s = 5; s <= 7; s++) begin
            send_packet(1'b1, 4'(s), $urandom());
        end
        send_packet(1'b1, 4'd4, $urandom());
        // full window held behind base 9, then one packet flushes eight
        for (int s = 10; s <= 16; s++) begin
            send_packet(1'b1, 4'(s), $urandom());
        end
        send_packet(1'b1, 4'd9, $urandom());

        foreach (win_list[p]) begin
            write_window(4'(win_list[p]));
            start = sent_count;
            while (sent_count - start < PHASE_ITEMS) begin
                send_round(win_list[p]);
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
